@@ rtl/core/rgbhsv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// shared sector codes for the rgb to hsv color unit
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // sector of the largest component, one-hot
  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_e;

endpackage

@@ rtl/core/rgbhsv_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_if
// valid/ready channel carrying three components of one request
// ----------------------------------------------------------------------------
interface rgbhsv_if #(
  parameter int unsigned W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] c0;
  logic [W-1:0] c1;
  logic [W-1:0] c2;

  modport source (output valid, output c0, output c1, output c2, input ready);
  modport sink   (input valid, input c0, input c1, input c2, output ready);
endinterface

@@ rtl/core/rgbhsv_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_div_cell
// one restoring step for both hue and saturation fractional quotients
// ----------------------------------------------------------------------------
module rgbhsv_div_cell #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [W+2:0] hrem_i,
  input  logic [W+2:0] hden_i,
  input  logic [W-1:0] hq_i,
  input  logic [W:0]   srem_i,
  input  logic [W-1:0] sden_i,
  input  logic [W-1:0] sq_i,
  input  logic [W-1:0] slow_i,
  input  logic [W-1:0] val_i,
  output logic         vld_o,
  output logic [W+2:0] hrem_o,
  output logic [W+2:0] hden_o,
  output logic [W-1:0] hq_o,
  output logic [W:0]   srem_o,
  output logic [W-1:0] sden_o,
  output logic [W-1:0] sq_o,
  output logic [W-1:0] slow_o,
  output logic [W-1:0] val_o
);
  logic [W+3:0] hsh;
  logic [W+1:0] ssh;
  logic         hge, sge;
  logic         vld_q;
  logic [W+2:0] hrem_q, hden_q;
  logic [W-1:0] hq_q, sq_q, sden_q, slow_q, val_q;
  logic [W:0]   srem_q;

  assign hsh = {hrem_i, 1'b0};
  // saturation brings down the next low numerator bit
  assign ssh = {srem_i, slow_i[W-1]};
  assign hge = hsh >= {1'b0, hden_i};
  assign sge = ssh >= {2'b00, sden_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hrem_q <= hge ? (W+3)'(hsh - {1'b0, hden_i}) : hsh[W+2:0];
      hden_q <= hden_i;
      hq_q   <= {hq_i[W-2:0], hge};
      srem_q <= sge ? (W+1)'(ssh - {2'b00, sden_i}) : ssh[W:0];
      sden_q <= sden_i;
      sq_q   <= {sq_i[W-2:0], sge};
      slow_q <= {slow_i[W-2:0], 1'b0};
      val_q  <= val_i;
    end
  end

  assign vld_o  = vld_q;
  assign hrem_o = hrem_q;
  assign hden_o = hden_q;
  assign hq_o   = hq_q;
  assign srem_o = srem_q;
  assign sden_o = sden_q;
  assign sq_o   = sq_q;
  assign slow_o = slow_q;
  assign val_o  = val_q;
endmodule

@@ rtl/core/rgb_to_hsv_color_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_color_unit
// hexcone rgb to hsv conversion in unsigned fixed point
// ----------------------------------------------------------------------------
// One request (red, green, blue) per clock goes in and one result (hue,
// saturation, brightness) per clock comes out. The path is one front
// stage that finds max, min and the hue numerator, then a chain of
// COMPONENT_BITS divider cells, each producing one quotient bit of hue
// and of saturation, then an output register.
// The whole chain advances together and stalls only when the result
// register is full and not taken.
module rgb_to_hsv_color_unit #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rgbhsv_if.sink      rgb_i,
  rgbhsv_if.source    hsv_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned W = COMPONENT_BITS;
  localparam int unsigned N = COMPONENT_BITS;

  logic [W-1:0] r, g, b, mx, mn, d, pos, neg;
  logic [W+2:0] six_d, t_off, t_wrap;
  logic [W+3:0] t_sum;
  logic [W+W-1:0] sat_num;
  sector_e      sec;
  logic         en;

  // chain taps; index 0 is the front stage output
  logic         vld  [N+1];
  logic [W+2:0] hrem [N+1];
  logic [W+2:0] hden [N+1];
  logic [W-1:0] hq   [N+1];
  logic [W:0]   srem [N+1];
  logic [W-1:0] sden [N+1];
  logic [W-1:0] sq   [N+1];
  logic [W-1:0] slow [N+1];
  logic [W-1:0] val  [N+1];

  logic         f_vld_q;
  logic [W+2:0] f_hrem_q, f_hden_q;
  logic [W:0]   f_srem_q;
  logic [W-1:0] f_sden_q, f_slow_q, f_val_q;
  logic         o_vld_q;
  logic [W-1:0] o_hue_q, o_sat_q, o_val_q;

  assign r = rgb_i.c0;
  assign g = rgb_i.c1;
  assign b = rgb_i.c2;

  // result register frees when taken; whole chain moves together
  assign en = !o_vld_q || hsv_o.ready;
  assign rgb_i.ready = en;

  always_comb begin
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // red wins ties, then green
    if (r == mx)      sec = SEC_RED;
    else if (g == mx) sec = SEC_GREEN;
    else              sec = SEC_BLUE;
    case (sec)
      SEC_RED: begin
        pos = g; neg = b; t_off = '0;
      end
      SEC_GREEN: begin
        pos = b; neg = r; t_off = {2'b00, d, 1'b0};
      end
      SEC_BLUE: begin
        pos = r; neg = g; t_off = {1'b0, d, 2'b00};
      end
      default: begin
        pos = g; neg = b; t_off = '0;
      end
    endcase
    six_d  = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
    // offset + 6d + difference reaches 11d, one bit wider than 6d
    t_sum  = (W+4)'(t_off) + (W+4)'(six_d) + (W+4)'(pos) - (W+4)'(neg);
    t_wrap = (t_sum >= (W+4)'(six_d)) ? (W+3)'(t_sum - (W+4)'(six_d))
                                      : (W+3)'(t_sum);
    // saturation numerator d * (2^W - 1) as d*2^W - d
    sat_num = {d, {W{1'b0}}} - (2*W)'(d);
  end

  // saturation divides sat_num by mx: the high half (below mx) seeds the
  // remainder and each cell brings down one bit of the low half

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= rgb_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_hrem_q <= (d == '0) ? '0 : t_wrap;
      f_hden_q <= (d == '0) ? (W+3)'(1) : six_d;
      f_srem_q <= {1'b0, sat_num[2*W-1:W]};
      f_sden_q <= (mx == '0) ? W'(1) : mx;
      f_slow_q <= sat_num[W-1:0];
      f_val_q  <= mx;
    end
  end

  assign vld[0]  = f_vld_q;
  assign hrem[0] = f_hrem_q;
  assign hden[0] = f_hden_q;
  assign hq[0]   = '0;
  assign srem[0] = f_srem_q;
  assign sden[0] = f_sden_q;
  assign sq[0]   = '0;
  assign slow[0] = f_slow_q;
  assign val[0]  = f_val_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rgbhsv_div_cell #(.W(W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[i]),
      .hrem_i (hrem[i]),
      .hden_i (hden[i]),
      .hq_i   (hq[i]),
      .srem_i (srem[i]),
      .sden_i (sden[i]),
      .sq_i   (sq[i]),
      .slow_i (slow[i]),
      .val_i  (val[i]),
      .vld_o  (vld[i+1]),
      .hrem_o (hrem[i+1]),
      .hden_o (hden[i+1]),
      .hq_o   (hq[i+1]),
      .srem_o (srem[i+1]),
      .sden_o (sden[i+1]),
      .sq_o   (sq[i+1]),
      .slow_o (slow[i+1]),
      .val_o  (val[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en) begin
      o_vld_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_hue_q <= hq[N];
      o_sat_q <= sq[N];
      o_val_q <= val[N];
    end
  end

  assign hsv_o.valid = o_vld_q;
  assign hsv_o.c0    = o_hue_q;
  assign hsv_o.c1    = o_sat_q;
  assign hsv_o.c2    = o_val_q;
endmodule
